FILE: design/ivps_pkg.sv
// ----------------------------------------------------------------------------
// ivps_pkg
// Shared types and constants for the irrigation valve and pump sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package ivps_pkg;

    localparam int ZONE_COUNT = 8;
    localparam int ZONES_USED = (ZONE_COUNT < 8) ? ZONE_COUNT : 8;
    localparam int ZIDX_W     = (ZONES_USED > 1) ? $clog2(ZONES_USED) : 1;

    localparam logic [3:0]  NO_ZONE     = 4'd8;
    localparam logic [31:0] DAY_SECONDS = 32'd86400;
    localparam logic [31:0] MAX32       = 32'hFFFF_FFFF;
    localparam logic [15:0] DELAY_RESET = 16'd1000;
    localparam logic [15:0] DELAY_SAT   = 16'hFFFF;

    // Day quotient of a 33-bit value: ((x >> 7) * DAY_RECIP) >> 36, exact below 2^33
    localparam int          DAY_SHIFT    = 7;
    localparam int          DAY_RECIP_SH = 36;
    localparam logic [26:0] DAY_RECIP    = 27'd101806633;

    // Divider geometry
    localparam int DIV_NUM_W = 33;
    localparam int DIV_DEN_W = 32;
    localparam int DIV_CNT_W = $clog2(DIV_NUM_W + 1);

    // Input actions
    localparam logic [2:0] ACT_TICK       = 3'd0;
    localparam logic [2:0] ACT_SET_PROG   = 3'd1;
    localparam logic [2:0] ACT_START_TEST = 3'd2;
    localparam logic [2:0] ACT_STOP_TEST  = 3'd3;
    localparam logic [2:0] ACT_START_FILL = 3'd4;

    // Configuration register indexes
    localparam logic [1:0] REG_AUTO_ENABLED = 2'd0;
    localparam logic [1:0] REG_OUTDOOR_MASK = 2'd1;
    localparam logic [1:0] REG_DELAY_TICKS  = 2'd2;

    typedef enum logic [2:0] {
        SEQ_IDLE       = 3'd0,
        SEQ_OPEN_FEED  = 3'd1,
        SEQ_OPEN_PUMP  = 3'd2,
        SEQ_CLOSE_PUMP = 3'd3,
        SEQ_CLOSE_FEED = 3'd4
    } seq_state_t;

    typedef enum logic [1:0] {
        MAN_NONE = 2'd0,
        MAN_RUN  = 2'd1,
        MAN_STOP = 2'd2,
        MAN_FILL = 2'd3
    } man_mode_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_PLAN,
        S_DIV1,
        S_MUL1,
        S_ADD1,
        S_CMP,
        S_DIV2,
        S_DIV2_WAIT,
        S_MUL2,
        S_ADD2,
        S_WR,
        S_RESULT
    } ctl_state_t;

    // Request to the divider
    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] num;
        logic [DIV_DEN_W-1:0] den;
    } div_req_t;

    // Reply from the divider
    typedef struct packed {
        logic                 done;
        logic [DIV_NUM_W-1:0] quot;
    } div_rsp_t;

endpackage

`default_nettype wire

FILE: design/ivps_div.sv
// ----------------------------------------------------------------------------
// ivps_div
// Restoring divider, one quotient bit per cycle; done pulses with the quotient.
// ----------------------------------------------------------------------------
`default_nettype none

module ivps_div (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire ivps_pkg::div_req_t req,
    output ivps_pkg::div_rsp_t     rsp
);

    logic                               busy_reg, busy_next;
    logic                               done_reg, done_next;
    logic [ivps_pkg::DIV_CNT_W-1:0]     cnt_reg, cnt_next;
    logic [ivps_pkg::DIV_DEN_W-1:0]     rem_reg, rem_next;
    logic [ivps_pkg::DIV_NUM_W-1:0]     q_reg, q_next;
    logic [ivps_pkg::DIV_DEN_W-1:0]     den_reg, den_next;
    logic [ivps_pkg::DIV_DEN_W:0]       shifted;
    logic [ivps_pkg::DIV_DEN_W+1:0]     diff;
    logic                               ge;

    // Trial subtract of one step
    assign shifted = {rem_reg, q_reg[ivps_pkg::DIV_NUM_W-1]};
    assign diff    = {1'b0, shifted} - {2'b00, den_reg};
    assign ge      = ~diff[ivps_pkg::DIV_DEN_W+1];

    // Load, step and finish
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        den_next  = den_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            q_next    = req.num;
            den_next  = req.den;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff[ivps_pkg::DIV_DEN_W-1:0] : shifted[ivps_pkg::DIV_DEN_W-1:0];
            q_next   = {q_reg[ivps_pkg::DIV_NUM_W-2:0], ge};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == ivps_pkg::DIV_CNT_W'(ivps_pkg::DIV_NUM_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        q_reg   <= q_next;
        den_reg <= den_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = q_reg;

endmodule

`default_nettype wire

FILE: design/irrigation_valve_pump_sequencer.sv
// ----------------------------------------------------------------------------
// irrigation_valve_pump_sequencer
// Valve and pump sequencing with per-zone programs, test runs and tank fill.
// ----------------------------------------------------------------------------
// Sequence: most words go from EXEC straight to the result; a tick that scans the
// zone table passes through SCAN until the first due zone or the last one; planning
// a next start runs a reciprocal multiply for the day, then, if that start is past,
// one 33-step division on the divider. done pulses one cycle; busy holds until then.
// Throughput: one word at a time; the next word can be taken in the cycle after done.
// Reset: control state and the zone table are cleared, configuration takes its reset values.
`default_nettype none

module irrigation_valve_pump_sequencer (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // command channel
    input  wire logic        start,
    output logic             busy,
    input  wire logic [2:0]  action,
    input  wire logic [31:0] now,
    input  wire logic        tank_has_water,
    input  wire logic        tank_filled,
    input  wire logic [2:0]  valve,
    input  wire logic        prog_mode,
    input  wire logic [31:0] prog_frequency,
    input  wire logic [16:0] prog_start_time,
    input  wire logic [31:0] prog_duration,
    input  wire logic [31:0] test_duration,
    // configuration channel
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    // result channel
    output logic             done,
    output logic [7:0]       valve_open_mask,
    output logic             outdoor_valve_open,
    output logic             fill_valve_open,
    output logic             main_feed_open,
    output logic             pump_on,
    output logic             accepted,
    output logic [3:0]       active_zone,
    output logic             testing,
    output logic             filling,
    output logic [31:0]      remaining_test_time,
    output logic [31:0]      fill_elapsed,
    output logic [31:0]      last_fill_time
);

    localparam int ZU = ivps_pkg::ZONES_USED;
    localparam int ZW = ivps_pkg::ZIDX_W;

    // configuration
    logic        auto_en_reg;
    logic [7:0]  outdoor_mask_reg;
    logic [15:0] delay_ticks_reg;

    // control state
    ivps_pkg::ctl_state_t ctl_reg, ctl_next;
    ivps_pkg::seq_state_t seq_reg, seq_next;
    ivps_pkg::man_mode_t  man_reg, man_next;
    logic [3:0]  zone_reg, zone_next;
    logic [15:0] dc_reg, dc_next;
    logic [31:0] test_end_reg, test_end_next;
    logic [31:0] fill_start_reg, fill_start_next;
    logic [31:0] fill_last_reg, fill_last_next;
    logic [7:0]  zv_reg, zv_next;
    logic        out_v_reg, out_v_next;
    logic        fill_v_reg, fill_v_next;
    logic        main_v_reg, main_v_next;
    logic        pump_reg, pump_next;
    logic        acc_reg, acc_next;
    logic [ZW-1:0] idx_reg, idx_next;

    // zone table
    logic        t_mode_reg  [ZU];
    logic [31:0] t_freq_reg  [ZU];
    logic [16:0] t_start_reg [ZU];
    logic [31:0] t_dur_reg   [ZU];
    logic [31:0] t_next_reg  [ZU];
    logic [31:0] t_stamp_reg [ZU];

    // latched word
    logic [2:0]  act_reg;
    logic [31:0] now_reg;
    logic        water_reg, full_reg;
    logic [2:0]  valve_reg;
    logic        pmode_reg;
    logic [31:0] pfreq_reg, pdur_reg, tdur_reg;
    logic [16:0] pstart_reg;

    // planning datapath
    logic [64:0] prod_reg, prod_next;
    logic [65:0] nxt_reg, nxt_next;
    logic [52:0] day_prod_reg, day_prod_next;
    logic [32:0] day_sum;
    logic [25:0] day_num;
    logic [16:0] day_quot;
    logic [32:0] mul_a;
    logic [31:0] mul_b;

    // table write strobes
    logic        wr_prog, wr_stamp, wr_next;

    ivps_pkg::div_req_t div_req;
    ivps_pkg::div_rsp_t div_rsp;

    logic        accept;
    logic        row_mode;
    logic [31:0] row_freq, row_dur, row_next, row_stamp;
    logic [16:0] row_start;
    logic [15:0] dc_inc;
    logic        dly_done;
    logic        run_over;
    logic [32:0] test_sum;
    logic [7:0]  zbit;

    assign accept    = start && !busy;
    assign busy      = (ctl_reg != ivps_pkg::S_IDLE);
    assign cfg_ready = 1'b1;

    // table read at the working index
    assign row_mode  = t_mode_reg[idx_reg];
    assign row_freq  = t_freq_reg[idx_reg];
    assign row_start = t_start_reg[idx_reg];
    assign row_dur   = t_dur_reg[idx_reg];
    assign row_next  = t_next_reg[idx_reg];
    assign row_stamp = t_stamp_reg[idx_reg];
    assign zbit      = 8'(1) << idx_reg;

    // saturating delay count
    assign dc_inc   = (dc_reg == ivps_pkg::DELAY_SAT) ? dc_reg : dc_reg + 16'd1;
    assign dly_done = (dc_inc >= delay_ticks_reg);

    assign run_over = (man_reg == ivps_pkg::MAN_RUN) ? (now_reg >= test_end_reg)
                    : ({1'b0, now_reg} >= ({1'b0, row_stamp} + {1'b0, row_dur}));
    assign test_sum = {1'b0, now_reg} + {1'b0, tdur_reg};

    // day number of now + frequency by reciprocal multiplication
    assign day_sum  = {1'b0, now_reg} + {1'b0, row_freq};
    assign day_num  = day_sum[32:ivps_pkg::DAY_SHIFT];
    assign day_quot = day_prod_reg[52:ivps_pkg::DAY_RECIP_SH];

    // shared multiplier operands
    assign mul_a = (ctl_reg == ivps_pkg::S_MUL1) ? {16'd0, day_quot} : div_rsp.quot + 33'd1;
    assign mul_b = (ctl_reg == ivps_pkg::S_MUL1) ? ivps_pkg::DAY_SECONDS : row_freq;

    // divider request for the stepping division
    always_comb
    begin
        div_req.start = (ctl_reg == ivps_pkg::S_DIV2);
        div_req.num   = {1'b0, now_reg - nxt_reg[31:0]};
        div_req.den   = row_freq;
    end

    ivps_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // next controller state
    always_comb
    begin
        ctl_next = ctl_reg;
        case (ctl_reg)
            ivps_pkg::S_IDLE:
                if (accept)
                    ctl_next = ivps_pkg::S_EXEC;
            ivps_pkg::S_EXEC:
            begin
                ctl_next = ivps_pkg::S_RESULT;
                if (act_reg == ivps_pkg::ACT_TICK)
                begin
                    if (seq_reg == ivps_pkg::SEQ_IDLE && man_reg != ivps_pkg::MAN_FILL
                        && zone_reg == ivps_pkg::NO_ZONE && auto_en_reg)
                        ctl_next = ivps_pkg::S_SCAN;
                    else if (seq_reg == ivps_pkg::SEQ_CLOSE_PUMP && dly_done
                             && man_reg != ivps_pkg::MAN_STOP && zone_reg < 4'(ZU))
                        ctl_next = ivps_pkg::S_PLAN;
                end
                else if (act_reg == ivps_pkg::ACT_SET_PROG && {1'b0, valve_reg} < 4'(ZU))
                    ctl_next = ivps_pkg::S_PLAN;
            end
            ivps_pkg::S_SCAN:
                if ((row_mode && now_reg >= row_next) || idx_reg == ZW'(ZU - 1))
                    ctl_next = ivps_pkg::S_RESULT;
            ivps_pkg::S_PLAN:
                ctl_next = (!row_mode || row_freq == 32'd0) ? ivps_pkg::S_WR
                                                           : ivps_pkg::S_DIV1;
            ivps_pkg::S_DIV1:      ctl_next = ivps_pkg::S_MUL1;
            ivps_pkg::S_MUL1:      ctl_next = ivps_pkg::S_ADD1;
            ivps_pkg::S_ADD1:      ctl_next = ivps_pkg::S_CMP;
            ivps_pkg::S_CMP:
                ctl_next = (nxt_reg <= {34'd0, now_reg}) ? ivps_pkg::S_DIV2 : ivps_pkg::S_WR;
            ivps_pkg::S_DIV2:      ctl_next = ivps_pkg::S_DIV2_WAIT;
            ivps_pkg::S_DIV2_WAIT:
                if (div_rsp.done)
                    ctl_next = ivps_pkg::S_MUL2;
            ivps_pkg::S_MUL2:      ctl_next = ivps_pkg::S_ADD2;
            ivps_pkg::S_ADD2:      ctl_next = ivps_pkg::S_WR;
            ivps_pkg::S_WR:        ctl_next = ivps_pkg::S_RESULT;
            ivps_pkg::S_RESULT:    ctl_next = ivps_pkg::S_IDLE;
            default:               ctl_next = ivps_pkg::S_IDLE;
        endcase
    end

    // datapath next values and table write strobes
    always_comb
    begin
        seq_next        = seq_reg;
        man_next        = man_reg;
        zone_next       = zone_reg;
        dc_next         = dc_reg;
        test_end_next   = test_end_reg;
        fill_start_next = fill_start_reg;
        fill_last_next  = fill_last_reg;
        zv_next         = zv_reg;
        out_v_next      = out_v_reg;
        fill_v_next     = fill_v_reg;
        main_v_next     = main_v_reg;
        pump_next       = pump_reg;
        acc_next        = acc_reg;
        idx_next        = idx_reg;
        prod_next       = prod_reg;
        nxt_next        = nxt_reg;
        day_prod_next   = day_prod_reg;
        wr_prog         = 1'b0;
        wr_stamp        = 1'b0;
        wr_next         = 1'b0;
        case (ctl_reg)
            ivps_pkg::S_IDLE:
                if (accept)
                begin
                    acc_next = 1'b0;
                    if (action == ivps_pkg::ACT_TICK)
                        idx_next = (zone_reg < 4'(ZU)) ? zone_reg[ZW-1:0] : '0;
                    else
                        idx_next = valve[ZW-1:0];
                end
            ivps_pkg::S_EXEC:
                case (act_reg)
                    ivps_pkg::ACT_TICK:
                        case (seq_reg)
                            ivps_pkg::SEQ_IDLE:
                                if (man_reg == ivps_pkg::MAN_FILL)
                                begin
                                    // close the main feed once full
                                    if (full_reg)
                                    begin
                                        fill_last_next = now_reg - fill_start_reg;
                                        main_v_next    = 1'b0;
                                        dc_next        = '0;
                                        seq_next       = ivps_pkg::SEQ_CLOSE_FEED;
                                    end
                                end
                                else if (zone_reg < 4'(ZU))
                                begin
                                    // stop on dry tank or end of run
                                    if (!water_reg || run_over)
                                    begin
                                        pump_next = 1'b0;
                                        dc_next   = '0;
                                        seq_next  = ivps_pkg::SEQ_CLOSE_PUMP;
                                        if (man_reg == ivps_pkg::MAN_RUN)
                                            man_next = ivps_pkg::MAN_STOP;
                                    end
                                end
                            ivps_pkg::SEQ_OPEN_FEED:
                            begin
                                dc_next = dc_inc;
                                if (dly_done)
                                begin
                                    main_v_next = 1'b1;
                                    seq_next    = ivps_pkg::SEQ_IDLE;
                                end
                            end
                            ivps_pkg::SEQ_OPEN_PUMP:
                            begin
                                dc_next = dc_inc;
                                if (dly_done)
                                begin
                                    pump_next = 1'b1;
                                    wr_stamp  = (man_reg == ivps_pkg::MAN_NONE)
                                                && (zone_reg < 4'(ZU));
                                    seq_next  = ivps_pkg::SEQ_IDLE;
                                end
                            end
                            ivps_pkg::SEQ_CLOSE_PUMP:
                            begin
                                dc_next = dc_inc;
                                if (dly_done)
                                begin
                                    if (zone_reg < 4'(ZU))
                                    begin
                                        zv_next = zv_reg & ~zbit;
                                        if (outdoor_mask_reg[idx_reg])
                                            out_v_next = 1'b0;
                                    end
                                    if (man_reg == ivps_pkg::MAN_STOP)
                                        man_next = ivps_pkg::MAN_NONE;
                                    zone_next = ivps_pkg::NO_ZONE;
                                    seq_next  = ivps_pkg::SEQ_IDLE;
                                end
                            end
                            ivps_pkg::SEQ_CLOSE_FEED:
                            begin
                                dc_next = dc_inc;
                                if (dly_done)
                                begin
                                    fill_v_next = 1'b0;
                                    man_next    = ivps_pkg::MAN_NONE;
                                    seq_next    = ivps_pkg::SEQ_IDLE;
                                end
                            end
                            default:
                                seq_next = ivps_pkg::SEQ_IDLE;
                        endcase
                    ivps_pkg::ACT_SET_PROG:
                        wr_prog = ({1'b0, valve_reg} < 4'(ZU));
                    ivps_pkg::ACT_START_TEST:
                        if (tdur_reg != 32'd0 && zone_reg == ivps_pkg::NO_ZONE
                            && man_reg != ivps_pkg::MAN_FILL && water_reg
                            && {1'b0, valve_reg} < 4'(ZU))
                        begin
                            test_end_next = test_sum[32] ? ivps_pkg::MAX32 : test_sum[31:0];
                            zone_next     = 4'(idx_reg);
                            zv_next       = zv_reg | zbit;
                            if (outdoor_mask_reg[idx_reg])
                                out_v_next = 1'b1;
                            dc_next  = '0;
                            seq_next = ivps_pkg::SEQ_OPEN_PUMP;
                            man_next = ivps_pkg::MAN_RUN;
                            acc_next = 1'b1;
                        end
                    ivps_pkg::ACT_STOP_TEST:
                        if (man_reg == ivps_pkg::MAN_RUN)
                        begin
                            pump_next = 1'b0;
                            dc_next   = '0;
                            seq_next  = ivps_pkg::SEQ_CLOSE_PUMP;
                            man_next  = ivps_pkg::MAN_STOP;
                        end
                    ivps_pkg::ACT_START_FILL:
                        if (zone_reg == ivps_pkg::NO_ZONE && !full_reg)
                        begin
                            fill_start_next = now_reg;
                            man_next        = ivps_pkg::MAN_FILL;
                            fill_v_next     = 1'b1;
                            dc_next         = '0;
                            seq_next        = ivps_pkg::SEQ_OPEN_FEED;
                            acc_next        = 1'b1;
                        end
                    default:
                        acc_next = 1'b0;
                endcase
            ivps_pkg::S_SCAN:
                // open the first due timer zone, else advance
                if (row_mode && now_reg >= row_next)
                begin
                    zone_next = 4'(idx_reg);
                    zv_next   = zv_reg | zbit;
                    if (outdoor_mask_reg[idx_reg])
                        out_v_next = 1'b1;
                    dc_next  = '0;
                    seq_next = ivps_pkg::SEQ_OPEN_PUMP;
                end
                else if (idx_reg != ZW'(ZU - 1))
                    idx_next = idx_reg + 1'b1;
            ivps_pkg::S_PLAN:
                nxt_next = '0;
            ivps_pkg::S_DIV1:
                day_prod_next = {27'd0, day_num} * {26'd0, ivps_pkg::DAY_RECIP};
            ivps_pkg::S_MUL1, ivps_pkg::S_MUL2:
                prod_next = {32'd0, mul_a} * {33'd0, mul_b};
            ivps_pkg::S_ADD1:
                nxt_next = {1'b0, prod_reg} + {49'd0, row_start};
            ivps_pkg::S_ADD2:
                nxt_next = nxt_reg + {1'b0, prod_reg};
            ivps_pkg::S_WR:
                wr_next = 1'b1;
            default:
                acc_next = acc_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg          <= ivps_pkg::S_IDLE;
            seq_reg          <= ivps_pkg::SEQ_IDLE;
            man_reg          <= ivps_pkg::MAN_NONE;
            zone_reg         <= ivps_pkg::NO_ZONE;
            dc_reg           <= '0;
            test_end_reg     <= '0;
            fill_start_reg   <= '0;
            fill_last_reg    <= '0;
            zv_reg           <= '0;
            out_v_reg        <= 1'b0;
            fill_v_reg       <= 1'b0;
            main_v_reg       <= 1'b0;
            pump_reg         <= 1'b0;
            acc_reg          <= 1'b0;
            idx_reg          <= '0;
            auto_en_reg      <= 1'b0;
            outdoor_mask_reg <= '0;
            delay_ticks_reg  <= ivps_pkg::DELAY_RESET;
            for (int i = 0; i < ZU; i++)
            begin
                t_mode_reg[i]  <= 1'b0;
                t_freq_reg[i]  <= '0;
                t_start_reg[i] <= '0;
                t_dur_reg[i]   <= '0;
                t_next_reg[i]  <= '0;
                t_stamp_reg[i] <= '0;
            end
        end
        else
        begin
            ctl_reg        <= ctl_next;
            seq_reg        <= seq_next;
            man_reg        <= man_next;
            zone_reg       <= zone_next;
            dc_reg         <= dc_next;
            test_end_reg   <= test_end_next;
            fill_start_reg <= fill_start_next;
            fill_last_reg  <= fill_last_next;
            zv_reg         <= zv_next;
            out_v_reg      <= out_v_next;
            fill_v_reg     <= fill_v_next;
            main_v_reg     <= main_v_next;
            pump_reg       <= pump_next;
            acc_reg        <= acc_next;
            idx_reg        <= idx_next;
            // configuration writes
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    ivps_pkg::REG_AUTO_ENABLED: auto_en_reg      <= cfg_data[0];
                    ivps_pkg::REG_OUTDOOR_MASK: outdoor_mask_reg <= cfg_data[7:0];
                    ivps_pkg::REG_DELAY_TICKS:  delay_ticks_reg  <= cfg_data;
                    default:                    auto_en_reg      <= auto_en_reg;
                endcase
            end
            // zone table writes at the working index
            if (wr_prog)
            begin
                t_mode_reg[idx_reg]  <= pmode_reg;
                t_freq_reg[idx_reg]  <= pfreq_reg;
                t_start_reg[idx_reg] <= pstart_reg;
                t_dur_reg[idx_reg]   <= pdur_reg;
            end
            if (wr_stamp)
                t_stamp_reg[idx_reg] <= now_reg;
            if (wr_next)
                t_next_reg[idx_reg] <= (|nxt_reg[65:32]) ? ivps_pkg::MAX32 : nxt_reg[31:0];
        end
    end

    // hold the accepted word and planning values
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            act_reg    <= action;
            now_reg    <= now;
            water_reg  <= tank_has_water;
            full_reg   <= tank_filled;
            valve_reg  <= valve;
            pmode_reg  <= prog_mode;
            pfreq_reg  <= prog_frequency;
            pstart_reg <= prog_start_time;
            pdur_reg   <= prog_duration;
            tdur_reg   <= test_duration;
        end
        prod_reg     <= prod_next;
        nxt_reg      <= nxt_next;
        day_prod_reg <= day_prod_next;
    end

    // result word
    assign done                = (ctl_reg == ivps_pkg::S_RESULT);
    assign valve_open_mask     = zv_reg;
    assign outdoor_valve_open  = out_v_reg;
    assign fill_valve_open     = fill_v_reg;
    assign main_feed_open      = main_v_reg;
    assign pump_on             = pump_reg;
    assign accepted            = acc_reg;
    assign active_zone         = zone_reg;
    assign testing             = (man_reg == ivps_pkg::MAN_RUN) || (man_reg == ivps_pkg::MAN_STOP);
    assign filling             = (man_reg == ivps_pkg::MAN_FILL);
    assign remaining_test_time = (testing && now_reg < test_end_reg) ? test_end_reg - now_reg
                                                                    : 32'd0;
    assign fill_elapsed        = !filling ? 32'd0
                               : (seq_reg == ivps_pkg::SEQ_CLOSE_FEED) ? fill_last_reg
                               : now_reg - fill_start_reg;
    assign last_fill_time      = fill_last_reg;

    // accepted word makes the block busy
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy)
        else $error("accepted word did not make the block busy");

    // pump runs only with a zone valve open
    a_pump_valve: assert property (@(posedge clk) disable iff (!rst_n)
        pump_reg |-> (zv_reg != 8'd0))
        else $error("pump running with no zone valve open");

    // no active zone means all zone valves closed
    a_no_zone_closed: assert property (@(posedge clk) disable iff (!rst_n)
        (zone_reg == ivps_pkg::NO_ZONE) |-> (zv_reg == 8'd0))
        else $error("zone valve open with no active zone");

endmodule

`default_nettype wire
